// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, suspended while reset is low.
`define PWIS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Property checked on every rising clock edge, reset included.
`define PWIS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- design/pwis_pkg.sv -----
package pwis_pkg;

  localparam int GAIN_W   = 16;
  localparam int ZONE_W   = 16;
  localparam int ILIM_W   = 31;
  localparam int OLIM_W   = 15;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int DMODE_W  = 2;
  // Serial multiplier operand: a sign-extended gain or a 16-bit magnitude.
  localparam int MUL_XW   = GAIN_W + 1;
  // Numerator of the speed-band ratio, product of two 16-bit magnitudes.
  localparam int NUM_W    = 2 * ZONE_W;

  localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OLIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DMODE = 3'd7;

  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;
  localparam logic [1:0] TERM_F = 2'd3;

endpackage

// ----- design/pwis_mul.sv -----
module pwis_mul #(
  parameter int YW = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [pwis_pkg::MUL_XW-1:0]    x_i,
  input  logic signed [YW-1:0]                  y_i,
  output logic                                  done_o,
  output logic signed [pwis_pkg::MUL_XW+YW-1:0] p_o
);

  localparam int XW    = pwis_pkg::MUL_XW;
  localparam int PW    = XW + YW;
  localparam int CNT_W = $clog2(XW);

  logic [XW-1:0]        x_q;
  logic signed [PW-1:0] y_q;
  logic signed [PW-1:0] acc_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic                 last;

  assign last = (cnt_q == CNT_W'(XW - 1));

  // One multiplier bit per cycle; the top bit carries negative weight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= PW'(y_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (x_q[0]) begin
        acc_q <= last ? (acc_q - y_q) : (acc_q + y_q);
      end
      x_q <= x_q >> 1;
      y_q <= y_q <<< 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ----- design/pwis_div.sv -----
module pwis_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pwis_pkg::NUM_W-1:0]    num_i,
  input  logic [pwis_pkg::ZONE_W-1:0]   den_i,
  output logic                          done_o,
  output logic [pwis_pkg::NUM_W-1:0]    quo_o
);

  localparam int NW    = pwis_pkg::NUM_W;
  localparam int DW    = pwis_pkg::ZONE_W;
  localparam int CNT_W = $clog2(NW);

  logic [NW-1:0]    quo_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DW:0]      rem_sh;
  logic [DW:0]      diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- design/pid_with_integral_shaping.sv -----
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_ready_o  target_i, measured_i, measured_rate_i
// result    out        out_valid_o/out_ready_i drive_o, drive_clamped_o
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// A request is taken in the idle state; its drive becomes valid, once the result register
// is free, in the same cycle in which the next request can be taken. Each of the four terms
// takes a start step, a run of the shared bit-serial multiplier and a hand-off step. An
// error inside the linear speed band adds one more multiplier run and a serial divider run.
// Reset clears the gains, limits, integral sum and history; the result register holds a
// finished drive while out_ready_i is low and a new request is taken meanwhile.
module pid_with_integral_shaping #(
  parameter int SAMPLE_WIDTH       = 16,
  parameter int INTEGRAL_WIDTH     = 32,
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      target_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      measured_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      measured_rate_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      drive_o,
  output logic                                drive_clamped_o,
  input  logic                                cfg_we_i,
  input  logic [pwis_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pwis_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int EW   = SW + 1;
  localparam int IW   = INTEGRAL_WIDTH;
  localparam int GW   = pwis_pkg::GAIN_W;
  localparam int ZW   = pwis_pkg::ZONE_W;
  localparam int BW   = (IW > SW + 2) ? IW : SW + 2;
  localparam int PW   = pwis_pkg::MUL_XW + BW;
  localparam int TW   = PW + 2;
  localparam int CW   = (EW > ZW + 1) ? EW : ZW + 1;
  localparam int LW   = ((IW > pwis_pkg::ILIM_W) ? IW : pwis_pkg::ILIM_W) + 1;
  localparam int SUMW = ((IW > EW) ? IW : EW) + 1;
  localparam int QW   = (EW > pwis_pkg::NUM_W) ? EW : pwis_pkg::NUM_W;

  localparam logic signed [TW-1:0]   HALF = (TW'(1) << GAIN_FRACTION_BITS) >> 1;
  localparam logic signed [TW-1:0]   SMAX = {{(TW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [TW-1:0]   SMIN = ~SMAX;
  localparam logic signed [SUMW-1:0] IMAX = {{(SUMW-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] IMIN = ~IMAX;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_MGO   = 4'd2;
  localparam logic [3:0] ST_MWAIT = 4'd3;
  localparam logic [3:0] ST_DGO   = 4'd4;
  localparam logic [3:0] ST_DWAIT = 4'd5;
  localparam logic [3:0] ST_INTEG = 4'd6;
  localparam logic [3:0] ST_TGO   = 4'd7;
  localparam logic [3:0] ST_TWAIT = 4'd8;
  localparam logic [3:0] ST_FINAL = 4'd9;

  // Configuration registers.
  logic signed [GW-1:0]              kp_q, ki_q, kd_q, kf_q;
  logic [pwis_pkg::ILIM_W-1:0]       ilim_q;
  logic [pwis_pkg::OLIM_W-1:0]       olim_q;
  logic [pwis_pkg::CFG_W-1:0]        zone_q;
  logic [pwis_pkg::DMODE_W-1:0]      dmode_q;

  // Controller state and working registers.
  logic [3:0]            state_q, state_d;
  logic [1:0]            tidx_q;
  logic signed [SW-1:0]  tgt_q, meas_q, rate_q, teff_q;
  logic signed [EW-1:0]  e_q, step_q;
  logic [EW-1:0]         a_q;
  logic                  sep_q;
  logic signed [IW-1:0]  isum_q;
  logic signed [EW-1:0]  prev_err_q;
  logic signed [SW-1:0]  prev_tgt_q, prev_meas_q;
  logic signed [TW-1:0]  acc_q;
  logic                  out_valid_q;
  logic signed [SW-1:0]  drive_q;
  logic                  clamped_q;

  logic [ZW-1:0] dz, sep, ba, bb;
  assign dz  = zone_q[ZW-1:0];
  assign sep = zone_q[2*ZW-1:ZW];
  assign ba  = zone_q[3*ZW-1:2*ZW];
  assign bb  = zone_q[4*ZW-1:3*ZW];

  // Error, dead zone and speed band selection.
  logic signed [EW-1:0] e_raw, e_p, step_p;
  logic [EW-1:0]        a_raw, a_p;
  logic signed [SW-1:0] teff_p;
  logic                 in_dz, bands_off, ge_b, le_a, lin_p, sep_p;

  always_comb begin
    e_raw     = EW'(tgt_q) - EW'(meas_q);
    a_raw     = e_raw[EW-1] ? EW'(-e_raw) : EW'(e_raw);
    in_dz     = CW'(a_raw) < CW'(dz);
    e_p       = in_dz ? '0 : e_raw;
    a_p       = in_dz ? '0 : a_raw;
    teff_p    = in_dz ? meas_q : tgt_q;
    bands_off = (ba == '0) && (bb == '0);
    ge_b      = CW'(a_p) >= CW'(bb);
    le_a      = CW'(a_p) <= CW'(ba);
    lin_p     = !bands_off && !ge_b && !le_a;
    step_p    = (!bands_off && ge_b) ? '0 : e_p;
    sep_p     = (sep != '0) && (CW'(a_p) >= CW'(sep));
  end

  // The stored sum is pulled inside the limit before this sample's step.
  logic signed [LW-1:0] isum_w, lim_w, isum_lim;
  always_comb begin
    isum_w   = LW'(isum_q);
    lim_w    = LW'({1'b0, ilim_q});
    isum_lim = isum_w;
    if (ilim_q != '0) begin
      if (isum_w > lim_w) begin
        isum_lim = lim_w;
      end else if (isum_w < -lim_w) begin
        isum_lim = -lim_w;
      end
    end
  end

  // Saturating integral update.
  logic signed [SUMW-1:0] isum_add;
  logic signed [IW-1:0]   isum_sat;
  always_comb begin
    isum_add = SUMW'(isum_q) + SUMW'(step_q);
    if (isum_add > IMAX) begin
      isum_sat = IW'(IMAX);
    end else if (isum_add < IMIN) begin
      isum_sat = IW'(IMIN);
    end else begin
      isum_sat = IW'(isum_add);
    end
  end

  // Shared multiplier, and the divider.
  logic                               mul_start, mul_done;
  logic signed [pwis_pkg::MUL_XW-1:0] mul_x;
  logic signed [BW-1:0]               mul_y;
  logic signed [PW-1:0]               mul_p;
  logic                               div_start, div_done;
  logic [pwis_pkg::NUM_W-1:0]         div_quo;
  logic [ZW-1:0]                      a_z;
  logic [QW-1:0]                      quo_w;

  assign a_z = ZW'(CW'(a_q));

  logic signed [BW-1:0] dop;
  always_comb begin
    if (dmode_q[1]) begin
      dop = BW'(rate_q);
    end else if (dmode_q[0]) begin
      dop = BW'(EW'(prev_meas_q) - EW'(meas_q));
    end else begin
      dop = BW'((SW+2)'(e_q) - (SW+2)'(prev_err_q));
    end
  end

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    if (state_q == ST_MGO) begin
      mul_x = {1'b0, a_z};
      mul_y = BW'({1'b0, bb - a_z});
    end else begin
      unique case (tidx_q)
        pwis_pkg::TERM_P: begin
          mul_x = pwis_pkg::MUL_XW'(kp_q);
          mul_y = BW'(e_q);
        end
        pwis_pkg::TERM_I: begin
          mul_x = pwis_pkg::MUL_XW'(ki_q);
          mul_y = BW'(isum_q);
        end
        pwis_pkg::TERM_D: begin
          mul_x = pwis_pkg::MUL_XW'(kd_q);
          mul_y = dop;
        end
        pwis_pkg::TERM_F: begin
          mul_x = pwis_pkg::MUL_XW'(kf_q);
          mul_y = BW'(EW'(teff_q) - EW'(prev_tgt_q));
        end
        default: begin
          mul_x = '0;
          mul_y = '0;
        end
      endcase
    end
  end

  assign mul_start = (state_q == ST_MGO) || (state_q == ST_TGO);
  assign div_start = (state_q == ST_DGO);

  pwis_mul #(.YW(BW)) u_pwis_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  pwis_div u_pwis_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_p[pwis_pkg::NUM_W-1:0]),
    .den_i   (bb - ba),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign quo_w = QW'(div_quo);

  // Rounding, output limit and saturation.
  logic signed [TW-1:0] shv, olim_w, lim1, fin;
  logic                 clamp_p;
  always_comb begin
    shv     = (acc_q + HALF) >>> GAIN_FRACTION_BITS;
    olim_w  = TW'({1'b0, olim_q});
    lim1    = shv;
    clamp_p = 1'b0;
    if (olim_q != '0) begin
      if (shv > olim_w) begin
        lim1    = olim_w;
        clamp_p = 1'b1;
      end else if (shv < -olim_w) begin
        lim1    = -olim_w;
        clamp_p = 1'b1;
      end
    end
    fin = lim1;
    if (lim1 > SMAX) begin
      fin     = SMAX;
      clamp_p = 1'b1;
    end else if (lim1 < SMIN) begin
      fin     = SMIN;
      clamp_p = 1'b1;
    end
  end

  logic in_acc, out_load;
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_load = (state_q == ST_FINAL) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = lin_p ? ST_MGO : ST_INTEG;
      ST_MGO:   state_d = ST_MWAIT;
      ST_MWAIT: if (mul_done) state_d = ST_DGO;
      ST_DGO:   state_d = ST_DWAIT;
      ST_DWAIT: if (div_done) state_d = ST_INTEG;
      ST_INTEG: state_d = ST_TGO;
      ST_TGO:   state_d = ST_TWAIT;
      ST_TWAIT: if (mul_done) state_d = (tidx_q == pwis_pkg::TERM_F) ? ST_FINAL : ST_TGO;
      ST_FINAL: if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tidx_q      <= '0;
      out_valid_q <= 1'b0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      kf_q        <= '0;
      ilim_q      <= '0;
      olim_q      <= '0;
      zone_q      <= '0;
      dmode_q     <= '0;
      isum_q      <= '0;
      prev_err_q  <= '0;
      prev_tgt_q  <= '0;
      prev_meas_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pwis_pkg::REG_KP:    kp_q    <= cfg_data_i[GW-1:0];
          pwis_pkg::REG_KI:    ki_q    <= cfg_data_i[GW-1:0];
          pwis_pkg::REG_KD:    kd_q    <= cfg_data_i[GW-1:0];
          pwis_pkg::REG_KF:    kf_q    <= cfg_data_i[GW-1:0];
          pwis_pkg::REG_ILIM:  ilim_q  <= cfg_data_i[pwis_pkg::ILIM_W-1:0];
          pwis_pkg::REG_OLIM:  olim_q  <= cfg_data_i[pwis_pkg::OLIM_W-1:0];
          pwis_pkg::REG_ZONE:  zone_q  <= cfg_data_i;
          pwis_pkg::REG_DMODE: dmode_q <= cfg_data_i[pwis_pkg::DMODE_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_PREP) begin
        isum_q <= IW'(isum_lim);
      end
      if (state_q == ST_INTEG) begin
        isum_q <= sep_q ? '0 : isum_sat;
        tidx_q <= '0;
      end
      if ((state_q == ST_TWAIT) && mul_done) begin
        tidx_q <= tidx_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        prev_err_q  <= e_q;
        prev_tgt_q  <= teff_q;
        prev_meas_q <= meas_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_q  <= target_i;
      meas_q <= measured_i;
      rate_q <= measured_rate_i;
    end
    if (state_q == ST_PREP) begin
      e_q    <= e_p;
      a_q    <= a_p;
      teff_q <= teff_p;
      step_q <= step_p;
      sep_q  <= sep_p;
    end
    if ((state_q == ST_DWAIT) && div_done) begin
      step_q <= e_q[EW-1] ? -$signed(quo_w[EW-1:0]) : $signed(quo_w[EW-1:0]);
    end
    if (state_q == ST_INTEG) begin
      acc_q <= '0;
    end
    if ((state_q == ST_TWAIT) && mul_done) begin
      acc_q <= acc_q + TW'(mul_p);
    end
    if (out_load) begin
      drive_q   <= fin[SW-1:0];
      clamped_q <= clamp_p;
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign drive_o         = drive_q;
  assign drive_clamped_o = clamped_q;

endmodule

// ----- design/pwis_checker.sv -----
`include "assert_macros.svh"

module pwis_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] drive_o,
  input logic                    drive_clamped_o
);

  // A waiting result holds until it is taken.
  `PWIS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o) && $stable(drive_clamped_o))

  // Reset leaves no result pending.
  `PWIS_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_valid_o)

  // An accepted request keeps the block busy, with in_ready_o low, after it is taken.
  `PWIS_ASSERT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)

endmodule

bind pid_with_integral_shaping pwis_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pwis_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .drive_o         (drive_o),
  .drive_clamped_o (drive_clamped_o)
);

// ----- bench/tb_pid_with_integral_shaping.sv -----
module tb_pid_with_integral_shaping;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [15:0] target_i;
  logic signed [15:0] measured_i;
  logic signed [15:0] measured_rate_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [15:0] drive_o;
  logic drive_clamped_o;
  logic cfg_we_i;
  logic [pwis_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [pwis_pkg::CFG_W-1:0] cfg_data_i;

  typedef struct packed {
    logic signed [15:0] drive;
    logic clamped;
  } drive_t;

  pid_with_integral_shaping DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .target_i(target_i), .measured_i(measured_i), .measured_rate_i(measured_rate_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .drive_o(drive_o), .drive_clamped_o(drive_clamped_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Predictor copy of the registers and the loop state.
  longint m_kp, m_ki, m_kd, m_kf, m_ilim, m_olim;
  logic [63:0] m_zone;
  logic [1:0] m_dmode;
  longint m_isum, m_perr, m_ptgt, m_pmeas;

  drive_t expected_drives[$];
  int mismatches;
  bit hold_off;
  int burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200000000;
    $display("tb_pid_with_integral_shaping: FAIL");
    $finish;
  end

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic drive_t compute_drive(longint tgt, longint meas, longint rate);
    longint dz, sep, ba, bb, e, a, stp, iterm, dterm, total, drv, c, mag;
    drive_t r;
    dz = m_zone[15:0];
    sep = m_zone[31:16];
    ba = m_zone[47:32];
    bb = m_zone[63:48];
    r.clamped = 1'b0;
    e = tgt - meas;
    a = (e < 0) ? -e : e;
    if (a < dz) begin
      tgt = meas;
      e = 0;
      a = 0;
    end
    if (ba == 0 && bb == 0) stp = e;
    else if (a >= bb) stp = 0;
    else if (a <= ba) stp = e;
    else begin
      mag = (a * (bb - a)) / (bb - ba);
      stp = (e < 0) ? -mag : mag;
    end
    if (m_ilim != 0) m_isum = clip(m_isum, -m_ilim, m_ilim);
    if (sep != 0 && a >= sep) begin
      m_isum = 0;
      iterm = 0;
    end else begin
      m_isum = clip(m_isum + stp, -64'sd2147483648, 64'sd2147483647);
      iterm = m_ki * m_isum;
    end
    if (m_dmode[1]) dterm = m_kd * rate;
    else if (m_dmode[0]) dterm = m_kd * (m_pmeas - meas);
    else dterm = m_kd * (e - m_perr);
    total = m_kp * e + iterm + dterm + m_kf * (tgt - m_ptgt);
    drv = (total + 128) >>> 8;
    if (m_olim != 0) begin
      c = clip(drv, -m_olim, m_olim);
      if (c != drv) r.clamped = 1'b1;
      drv = c;
    end
    c = clip(drv, -32768, 32767);
    if (c != drv) r.clamped = 1'b1;
    r.drive = c[15:0];
    m_perr = e;
    m_ptgt = tgt;
    m_pmeas = meas;
    return r;
  endfunction

  task automatic write_reg(logic [pwis_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pwis_pkg::REG_KP: m_kp = longint'($signed(val[15:0]));
      pwis_pkg::REG_KI: m_ki = longint'($signed(val[15:0]));
      pwis_pkg::REG_KD: m_kd = longint'($signed(val[15:0]));
      pwis_pkg::REG_KF: m_kf = longint'($signed(val[15:0]));
      pwis_pkg::REG_ILIM: m_ilim = val[30:0];
      pwis_pkg::REG_OLIM: m_olim = val[14:0];
      pwis_pkg::REG_ZONE: m_zone = val;
      pwis_pkg::REG_DMODE: m_dmode = val[1:0];
      default: ;
    endcase
  endtask

  // Sends one request; the sender idles between bursts of random length.
  task automatic send_request(logic [15:0] tgt, logic [15:0] meas, logic [15:0] rate);
    @(posedge clk_i);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    target_i <= tgt;
    measured_i <= meas;
    measured_rate_i <= rate;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_drives.push_back(compute_drive(longint'($signed(tgt)),
      longint'($signed(meas)), longint'($signed(rate))));
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    drive_t exp_d;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected drive %0d", drive_o);
      end else begin
        exp_d = expected_drives.pop_front();
        if (exp_d.drive !== drive_o || exp_d.clamped !== drive_clamped_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive mismatch: expected %0d/%0b, got %0d/%0b",
              exp_d.drive, exp_d.clamped, drive_o, drive_clamped_o);
        end
      end
    end
  end

  // Receiver stall pattern, overridden by a long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [63:0] rand_zone();
    return {16'($urandom_range(0, 3000)), 16'($urandom_range(0, 1500)),
            16'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20000)),
            16'($urandom_range(0, 40))};
  endfunction

  task automatic random_gains();
    write_reg(pwis_pkg::REG_KP, 64'($urandom));
    write_reg(pwis_pkg::REG_KI,
      64'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 64)));
    write_reg(pwis_pkg::REG_KD, 64'($urandom));
    write_reg(pwis_pkg::REG_KF, 64'($urandom));
    write_reg(pwis_pkg::REG_ILIM, {$urandom, $urandom});
    write_reg(pwis_pkg::REG_OLIM, ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom));
    write_reg(pwis_pkg::REG_ZONE,
      ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : rand_zone());
    write_reg(pwis_pkg::REG_DMODE, 64'($urandom));
  endtask

  task automatic test_directed();
    logic [15:0] ext[4];
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    write_reg(pwis_pkg::REG_KP, 64'h7fff);
    write_reg(pwis_pkg::REG_KI, 64'h8000);
    write_reg(pwis_pkg::REG_KD, 64'h0100);
    write_reg(pwis_pkg::REG_KF, 64'hffff);
    foreach (ext[i]) send_request(ext[i], ext[3 - i], ext[i]);
    write_reg(pwis_pkg::REG_OLIM, 64'h7fff);
    write_reg(pwis_pkg::REG_ILIM, 64'h7fffffff);
    write_reg(pwis_pkg::REG_DMODE, 64'd1);
    send_request(16'h7fff, 16'h8000, 16'h1234);
    write_reg(pwis_pkg::REG_DMODE, 64'd3);
    send_request(16'h8000, 16'h7fff, 16'h8000);
    // Dead zone, separation and speed band all active.
    write_reg(pwis_pkg::REG_ZONE, {16'd400, 16'd100, 16'd1000, 16'd10});
    write_reg(pwis_pkg::REG_OLIM, 64'd100);
    write_reg(pwis_pkg::REG_ILIM, 64'd50);
    write_reg(pwis_pkg::REG_DMODE, 64'd0);
    send_request(16'd5, 16'd0, 16'd0);
    send_request(16'd50, 16'd0, 16'd0);
    send_request(16'd250, 16'd0, 16'd0);
    send_request(16'd400, 16'd0, 16'd0);
    send_request(16'd2000, 16'd0, 16'd0);
    // Bands out of order.
    write_reg(pwis_pkg::REG_ZONE, {16'd100, 16'd300, 16'd0, 16'd0});
    send_request(16'd50, 16'd0, 16'd0);
    send_request(16'd200, 16'd0, 16'd0);
    write_reg(pwis_pkg::REG_ZONE, 64'hffff_ffff_ffff_ffff);
    send_request(16'h7fff, 16'h8000, 16'd0);
    send_request(16'd3, 16'd2, 16'd0);
  endtask

  task automatic test_random();
    for (int p = 0; p < 15; p++) begin
      random_gains();
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 3) == 0)
          send_request(16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_request(16'($signed($urandom_range(0, 4000)) - 2000),
            16'($signed($urandom_range(0, 4000)) - 2000), 16'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      repeat (600) @(posedge clk_i);
      for (int n = 0; n < 8; n++) send_request(16'($urandom), 16'($urandom), 16'($urandom));
    join_any
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
    wait fork;
  endtask

  initial begin
    int wait_cycles;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    target_i = '0;
    measured_i = '0;
    measured_rate_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    hold_off = 1'b0;
    mismatches = 0;
    burst_left = 0;
    m_kp = 0; m_ki = 0; m_kd = 0; m_kf = 0; m_ilim = 0; m_olim = 0;
    m_zone = '0; m_dmode = '0;
    m_isum = 0; m_perr = 0; m_ptgt = 0; m_pmeas = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    wait_cycles = 0;
    while (expected_drives.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_drives.size() == 0)
      $display("tb_pid_with_integral_shaping: PASS");
    else
      $display("tb_pid_with_integral_shaping: FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/pwis_pkg.sv
design/pwis_mul.sv
design/pwis_div.sv
design/pid_with_integral_shaping.sv
design/pwis_checker.sv
bench/tb_pid_with_integral_shaping.sv
